// ----- hdl/msfr_pkg.sv -----
`default_nettype none

package msfr_pkg;

  localparam int PAYLOAD_BYTES_DEF    = 32;
  localparam int HYSTERESIS_FLOOR_DEF = 4;
  localparam int CONTRAST_SHIFT_DEF   = 3;

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] NOMINAL_RESET  = 16'd4096;

  localparam logic [3:0] REG_HALF_BIT     = 4'd0;
  localparam logic [3:0] REG_PREAMBLE     = 4'd1;
  localparam logic [3:0] REG_DECAY_SHIFT  = 4'd2;
  localparam logic [3:0] REG_START_BYTE   = 4'd3;
  localparam logic [3:0] REG_START_LIMIT  = 4'd4;
  localparam logic [3:0] REG_LOST_LIMIT   = 4'd5;
  localparam logic [3:0] REG_MIN_SWING    = 4'd6;
  localparam logic [3:0] REG_MIN_DELTA    = 4'd7;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_FAIL  = 3'd2,
    KIND_LEN_ERR   = 3'd3,
    KIND_START_TO  = 3'd4,
    KIND_LOCK_LOST = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_SEARCH, PH_START, PH_LENGTH, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO
  } phase_t;

  typedef enum logic [1:0] {LIGHT_UNKNOWN, LIGHT_LOW, LIGHT_HIGH} light_t;

  // Q8 to sample index, round half up, clipped to 0 .. 2^32-1
  function automatic logic [31:0] round_q8(input logic signed [41:0] v);
    logic signed [41:0] t;
    t = v + 42'sd128;
    if (v <= 42'sd0) return 32'd0;
    if (t[41:40] != 2'd0) return 32'hFFFF_FFFF;
    return t[39:8];
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/manchester_sample_frame_receiver_top.sv -----
`default_nettype none

// Manchester frame receiver for one light sensor: one converter sample per request on
// the input channel. Each sample runs through a five step sequencer (envelope update,
// level and edge detection, preamble or DPLL edge handling, scheduled half-bit decode,
// and, when the decode completes a bit, bit and byte parsing); a second sample is held
// in an input register meanwhile, and the input stalls while that register is full. A
// sample that ends a good frame also replays the payload store, one memory read and then
// one result per byte, then the frame-good result; the input stalls while these drain.
module manchester_sample_frame_receiver_top #(
  parameter int PAYLOAD_BYTES    = msfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int HYSTERESIS_FLOOR = msfr_pkg::HYSTERESIS_FLOOR_DEF,
  parameter int CONTRAST_SHIFT   = msfr_pkg::CONTRAST_SHIFT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data,
  output logic [15:0]      out_frame_crc,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int PW = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [PW-1:0] POS_FULL = PW'(PAYLOAD_BYTES);
  localparam logic [15:0] HYST_FLOOR = 16'(HYSTERESIS_FLOOR);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ENV, ST_LVL, ST_EVT, ST_DEC, ST_BIT, ST_STAT, ST_FRD, ST_FOUT, ST_FEND
  } state_t;

  // configuration
  logic [5:0]  half_r;
  logic [7:0]  preamble_r, start_byte_r, start_limit_r, lost_limit_r;
  logic [3:0]  decay_r;
  logic [15:0] min_swing_r, min_delta_r;

  // receiver state
  state_t                state_r;
  logic [15:0]           buf_r, s_r;
  logic                  buf_valid_r;
  logic                  init_r, edge_r, rising_r, bit_val_r;
  logic [15:0]           strength_r;
  logic [31:0]           sample_counter_r;
  logic                  tracker_ready_r;
  logic signed [25:0]    low_env_r, high_env_r;
  msfr_pkg::light_t      light_r;
  logic [15:0]           contrast_r;
  msfr_pkg::phase_t      phase_r;
  logic                  search_started_r, search_prev_rising_r;
  logic [7:0]            search_edge_count_r;
  logic [31:0]           search_prev_at_r;
  logic [23:0]           search_period_r;
  logic signed [40:0]    bit_center_r;
  logic [15:0]           bit_period_r;
  logic signed [8:0]     phase_nudge_r;
  logic                  center_seen_r;
  logic [7:0]            missed_r;
  logic                  first_taken_r;
  logic [15:0]           first_sample_r;
  logic [7:0]            start_shift_r, start_bits_r, byte_shift_r;
  logic [2:0]            byte_cnt_r;
  logic [15:0]           crc_run_r, crc_rcv_r;
  logic [PW-1:0]         pos_r;
  logic [7:0]            flen_r;

  // result staging
  msfr_pkg::kind_t       em_kind_r;
  logic [7:0]            em_len_r;
  logic [15:0]           em_crc_r;
  logic [PW-1:0]         em_idx_r;
  logic [7:0]            mem_r [PAYLOAD_BYTES];
  logic [7:0]            mem_q_r;
  logic                  out_valid_r, out_last_r;
  msfr_pkg::kind_t       out_kind_r;
  logic [7:0]            out_data_r;
  logic [15:0]           out_crc_r;

  assign in_stall      = buf_valid_r;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data      = out_data_r;
  assign out_frame_crc = out_crc_r;
  assign out_last      = out_last_r;

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // period limits
  logic [5:0]  h_eff;
  logic [6:0]  full_w;
  logic [15:0] nom_w, plo_w, phi_w;
  always_comb begin
    h_eff  = (half_r < 6'd2) ? 6'd2 : half_r;
    full_w = {h_eff, 1'b0};
    nom_w  = {1'b0, full_w, 8'd0};
    plo_w  = {1'b0, full_w - 7'd3, 8'd0};
    phi_w  = {({1'b0, full_w} + 8'd3), 8'd0};
  end

  // envelope update
  logic signed [25:0] sq_w, dl_w, dh_w, low_nxt, high_nxt;
  always_comb begin
    sq_w     = $signed({2'b00, s_r, 8'd0});
    dl_w     = sq_w - low_env_r;
    dh_w     = sq_w - high_env_r;
    low_nxt  = low_env_r + (dl_w >>> ((sq_w < low_env_r) ? 4'd2 : decay_r));
    high_nxt = high_env_r + (dh_w >>> ((sq_w > high_env_r) ? 4'd2 : decay_r));
  end

  // swing, midpoint and hysteresis
  logic [25:0]        env_diff_w;
  logic [15:0]        sw_w, hy_w;
  logic signed [27:0] mid_w, hyst_w, sq28_w;
  always_comb begin
    env_diff_w = 26'(high_env_r - low_env_r);
    sw_w   = (tracker_ready_r && high_env_r > low_env_r) ? env_diff_w[23:8] : 16'd0;
    mid_w  = (28'(low_env_r) + 28'(high_env_r)) >>> 1;
    hy_w   = ({3'b000, sw_w[15:3]} < HYST_FLOOR) ? HYST_FLOOR : {3'b000, sw_w[15:3]};
    hyst_w = $signed({4'b0000, hy_w, 8'd0});
    sq28_w = 28'(sq_w);
  end

  // preamble edge
  logic [31:0]        intv_w;
  logic [13:0]        stol_w;
  logic signed [33:0] serr_w, stol_s;
  logic               sgood_w, sreach_w;
  logic signed [41:0] sdp_w, sp_sum_w;
  logic [23:0]        sp_new_w;
  logic [7:0]         scount_w;
  logic [40:0]        bc_seed_w;
  logic [15:0]        bp_seed_w;
  always_comb begin
    intv_w   = sample_counter_r - search_prev_at_r;
    stol_w   = (search_period_r[23:10] < 14'd3) ? 14'd3 : search_period_r[23:10];
    stol_s   = $signed({20'd0, stol_w});
    serr_w   = $signed({2'b00, intv_w}) - $signed({18'd0, search_period_r[23:8]});
    sgood_w  = (rising_r != search_prev_rising_r) && serr_w >= -stol_s && serr_w <= stol_s;
    sdp_w    = $signed({2'b00, intv_w, 8'd0}) - $signed({18'd0, search_period_r});
    sp_sum_w = $signed({18'd0, search_period_r}) + (sdp_w >>> 2);
    if (sp_sum_w < 42'sd0) sp_new_w = 24'd0;
    else if (sp_sum_w > 42'sd16777215) sp_new_w = 24'hFF_FFFF;
    else sp_new_w = sp_sum_w[23:0];
    scount_w  = (search_edge_count_r < 8'hFF) ? search_edge_count_r + 8'd1 : 8'hFF;
    sreach_w  = scount_w >= preamble_r;
    bc_seed_w = {1'b0, sample_counter_r, 8'd0} + {17'd0, sp_new_w};
    if (sp_new_w < {8'd0, plo_w}) bp_seed_w = plo_w;
    else if (sp_new_w > {8'd0, phi_w}) bp_seed_w = phi_w;
    else bp_seed_w = sp_new_w[15:0];
  end

  // DPLL edge
  logic [31:0]        pdiff_w;
  logic signed [31:0] perr_w, ptol_s;
  logic [5:0]         ptol_w;
  logic               pwithin_w;
  logic signed [8:0]  pnudge_w;
  logic signed [19:0] pbp_w;
  logic [15:0]        pbp_new_w;
  always_comb begin
    pdiff_w   = sample_counter_r - msfr_pkg::round_q8(42'(bit_center_r));
    perr_w    = $signed(pdiff_w);
    ptol_w    = (bit_period_r[15:10] < 6'd3) ? 6'd3 : bit_period_r[15:10];
    ptol_s    = $signed({26'd0, ptol_w});
    pwithin_w = perr_w >= -ptol_s && perr_w <= ptol_s;
    if (perr_w > 32'sd2) pnudge_w = 9'sd128;
    else if (perr_w < -32'sd2) pnudge_w = -9'sd128;
    else pnudge_w = $signed({perr_w[2:0], 6'd0});
    pbp_w = $signed({4'd0, bit_period_r}) + $signed({perr_w[16:0], 3'b000});
    if (pbp_w < $signed({4'd0, plo_w})) pbp_new_w = plo_w;
    else if (pbp_w > $signed({4'd0, phi_w})) pbp_new_w = phi_w;
    else pbp_new_w = pbp_w[15:0];
  end

  // scheduled decode
  logic [31:0]        first_at_w, second_at_w;
  logic               fcond_w, ft_w, scond_w;
  logic [15:0]        fs_w, strength_w, adapt_w, thr_w, str_eff_w;
  logic signed [16:0] delta_w;
  logic [31:0]        div_c_w, div_s_w;
  always_comb begin
    first_at_w  = msfr_pkg::round_q8(42'(bit_center_r) - 42'(bit_period_r[15:2]));
    second_at_w = msfr_pkg::round_q8(42'(bit_center_r) + 42'(bit_period_r[15:2]));
    fcond_w     = !first_taken_r && sample_counter_r >= first_at_w;
    ft_w        = first_taken_r || fcond_w;
    fs_w        = fcond_w ? s_r : first_sample_r;
    scond_w     = ft_w && sample_counter_r >= second_at_w;
    delta_w     = $signed({1'b0, s_r}) - $signed({1'b0, fs_w});
    strength_w  = delta_w[16] ? 16'(-delta_w) : delta_w[15:0];
    // divide by three (contrast) or six (swing) through the reciprocal, exact for 16-bit operands
    div_c_w     = contrast_r * 32'd43691;
    div_s_w     = sw_w * 32'd43691;
    adapt_w     = (contrast_r != 16'd0) ? {1'b0, div_c_w[31:17]} : {2'b00, div_s_w[31:18]};
    thr_w       = (adapt_w > min_delta_r) ? adapt_w : min_delta_r;
    str_eff_w   = (strength_w < thr_w) ? thr_w : strength_w;
  end

  // bit and byte parsing
  logic               rs_w, emit_w, mem_we_w;
  msfr_pkg::kind_t    ev_kind_w;
  logic [15:0]        contrast_new_w;
  logic signed [16:0] cdiff_w;
  logic [7:0]         ss_w, bs_w;
  logic [8:0]         sbits_w, missed_w;
  logic [PW-1:0]      pos_inc_w;
  logic [15:0]        crc_next_w, rcv_full_w;
  always_comb begin
    cdiff_w        = $signed({1'b0, strength_r}) - $signed({1'b0, contrast_r});
    contrast_new_w = (contrast_r == 16'd0) ? strength_r
                   : 16'($signed({1'b0, contrast_r}) + (cdiff_w >>> CONTRAST_SHIFT));
    ss_w       = {start_shift_r[6:0], bit_val_r};
    bs_w       = {byte_shift_r[6:0], bit_val_r};
    sbits_w    = {1'b0, start_bits_r} + 9'd1;
    missed_w   = {1'b0, missed_r} + 9'd1;
    pos_inc_w  = pos_r + PW'(1);
    crc_next_w = msfr_pkg::crc_byte(crc_run_r, bs_w);
    rcv_full_w = {crc_rcv_r[15:8], bs_w};
    rs_w       = 1'b0;
    emit_w     = 1'b0;
    mem_we_w   = 1'b0;
    ev_kind_w  = msfr_pkg::KIND_LOCK_LOST;
    if (phase_r == msfr_pkg::PH_START) begin
      if (ss_w != start_byte_r && sbits_w > {1'b0, start_limit_r}) begin
        rs_w = 1'b1; emit_w = 1'b1; ev_kind_w = msfr_pkg::KIND_START_TO;
      end
    end else if (byte_cnt_r == 3'd7) begin
      case (phase_r)
        msfr_pkg::PH_PAYLOAD: begin
          if (pos_r >= POS_FULL) begin
            rs_w = 1'b1; emit_w = 1'b1; ev_kind_w = msfr_pkg::KIND_LEN_ERR;
          end else begin
            mem_we_w = 1'b1;
          end
        end
        msfr_pkg::PH_CRC_LO: begin
          rs_w = 1'b1; emit_w = 1'b1;
          ev_kind_w = (rcv_full_w == crc_run_r) ? msfr_pkg::KIND_GOOD : msfr_pkg::KIND_CRC_FAIL;
        end
        default: ;
      endcase
    end
    if (!rs_w && !center_seen_r && missed_w > {1'b0, lost_limit_r}) begin
      rs_w = 1'b1; emit_w = 1'b1; ev_kind_w = msfr_pkg::KIND_LOCK_LOST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 6'd8; preamble_r <= 8'd12; decay_r <= 4'd5; start_byte_r <= 8'd213;
      start_limit_r <= 8'd64; lost_limit_r <= 8'd8; min_swing_r <= 16'd32;
      min_delta_r <= 16'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msfr_pkg::REG_HALF_BIT:    half_r        <= cfg_data[5:0];
        msfr_pkg::REG_PREAMBLE:    preamble_r    <= cfg_data[7:0];
        msfr_pkg::REG_DECAY_SHIFT: decay_r       <= cfg_data[3:0];
        msfr_pkg::REG_START_BYTE:  start_byte_r  <= cfg_data[7:0];
        msfr_pkg::REG_START_LIMIT: start_limit_r <= cfg_data[7:0];
        msfr_pkg::REG_LOST_LIMIT:  lost_limit_r  <= cfg_data[7:0];
        msfr_pkg::REG_MIN_SWING:   min_swing_r   <= cfg_data;
        msfr_pkg::REG_MIN_DELTA:   min_delta_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we_w && state_r == ST_BIT) mem_r[pos_r[AW-1:0]] <= bs_w;
    if (state_r == ST_FRD) mem_q_r <= mem_r[em_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; buf_valid_r <= 1'b0; out_valid_r <= 1'b0;
      sample_counter_r <= 32'd0; tracker_ready_r <= 1'b0;
      low_env_r <= 26'sd0; high_env_r <= 26'sd0; light_r <= msfr_pkg::LIGHT_UNKNOWN;
      contrast_r <= 16'd0; init_r <= 1'b0; edge_r <= 1'b0;
      phase_r <= msfr_pkg::PH_SEARCH; search_started_r <= 1'b0;
      search_prev_rising_r <= 1'b0; search_edge_count_r <= 8'd0;
      search_prev_at_r <= 32'd0; search_period_r <= {8'd0, msfr_pkg::NOMINAL_RESET};
      bit_center_r <= 41'sd0; bit_period_r <= msfr_pkg::NOMINAL_RESET;
      phase_nudge_r <= 9'sd0; center_seen_r <= 1'b0; missed_r <= 8'd0;
      first_taken_r <= 1'b0; first_sample_r <= 16'd0;
      start_shift_r <= 8'd0; start_bits_r <= 8'd0; byte_shift_r <= 8'd0;
      byte_cnt_r <= 3'd0; crc_run_r <= msfr_pkg::CRC_INIT; crc_rcv_r <= 16'd0;
      pos_r <= '0; flen_r <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        buf_r <= in_sample;
        buf_valid_r <= 1'b1;
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (buf_valid_r) begin
            s_r <= buf_r;
            buf_valid_r <= 1'b0;
            state_r <= ST_ENV;
          end
        end
        ST_ENV: begin
          init_r <= !tracker_ready_r;
          if (!tracker_ready_r) begin
            tracker_ready_r <= 1'b1;
            low_env_r <= sq_w;
            high_env_r <= sq_w;
            light_r <= msfr_pkg::LIGHT_UNKNOWN;
          end else begin
            low_env_r <= low_nxt;
            high_env_r <= high_nxt;
          end
          state_r <= ST_LVL;
        end
        ST_LVL: begin
          edge_r <= 1'b0;
          if (!init_r) begin
            if (sw_w < min_swing_r) begin
              light_r <= msfr_pkg::LIGHT_UNKNOWN;
            end else if (light_r == msfr_pkg::LIGHT_UNKNOWN) begin
              light_r <= (sq28_w >= mid_w) ? msfr_pkg::LIGHT_HIGH : msfr_pkg::LIGHT_LOW;
            end else if (light_r == msfr_pkg::LIGHT_LOW && sq28_w > mid_w + hyst_w) begin
              light_r <= msfr_pkg::LIGHT_HIGH; edge_r <= 1'b1; rising_r <= 1'b1;
            end else if (light_r == msfr_pkg::LIGHT_HIGH && sq28_w < mid_w - hyst_w) begin
              light_r <= msfr_pkg::LIGHT_LOW; edge_r <= 1'b1; rising_r <= 1'b0;
            end
          end
          state_r <= ST_EVT;
        end
        ST_EVT: begin
          if (edge_r && phase_r == msfr_pkg::PH_SEARCH) begin
            search_prev_rising_r <= rising_r;
            search_prev_at_r <= sample_counter_r;
            if (!search_started_r || !sgood_w) begin
              search_started_r <= 1'b1;
              search_edge_count_r <= 8'd1;
              search_period_r <= {8'd0, nom_w};
            end else begin
              search_period_r <= sp_new_w;
              search_edge_count_r <= scount_w;
              if (sreach_w) begin
                // lock: seed the DPLL and start hunting the start byte
                phase_r <= msfr_pkg::PH_START;
                start_shift_r <= 8'd0; start_bits_r <= 8'd0; byte_shift_r <= 8'd0;
                byte_cnt_r <= 3'd0; crc_run_r <= msfr_pkg::CRC_INIT; crc_rcv_r <= 16'd0;
                pos_r <= '0; flen_r <= 8'd0;
                bit_center_r <= $signed(bc_seed_w);
                bit_period_r <= bp_seed_w;
                phase_nudge_r <= 9'sd0; center_seen_r <= 1'b0; missed_r <= 8'd0;
                first_taken_r <= 1'b0;
              end
            end
          end else if (edge_r && pwithin_w) begin
            phase_nudge_r <= pnudge_w;
            bit_period_r <= pbp_new_w;
            center_seen_r <= 1'b1;
          end
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (phase_r != msfr_pkg::PH_SEARCH) begin
            first_taken_r <= ft_w;
            first_sample_r <= fs_w;
          end
          bit_val_r <= delta_w > 17'sd0;
          strength_r <= str_eff_w;
          if (phase_r != msfr_pkg::PH_SEARCH && scond_w) begin
            state_r <= ST_BIT;
          end else begin
            sample_counter_r <= sample_counter_r + 32'd1;
            state_r <= ST_IDLE;
          end
        end
        ST_BIT: begin
          sample_counter_r <= sample_counter_r + 32'd1;
          contrast_r <= contrast_new_w;
          if (phase_r == msfr_pkg::PH_START) begin
            start_shift_r <= ss_w;
            start_bits_r <= sbits_w[7:0];
            if (ss_w == start_byte_r) begin
              phase_r <= msfr_pkg::PH_LENGTH;
              byte_shift_r <= 8'd0; byte_cnt_r <= 3'd0; crc_run_r <= msfr_pkg::CRC_INIT;
              crc_rcv_r <= 16'd0; pos_r <= '0; flen_r <= 8'd0;
            end
          end else if (byte_cnt_r != 3'd7) begin
            byte_shift_r <= bs_w;
            byte_cnt_r <= byte_cnt_r + 3'd1;
          end else begin
            byte_shift_r <= 8'd0;
            byte_cnt_r <= 3'd0;
            case (phase_r)
              msfr_pkg::PH_LENGTH: begin
                flen_r <= bs_w;
                pos_r <= '0;
                crc_run_r <= msfr_pkg::crc_byte(msfr_pkg::CRC_INIT, bs_w);
                phase_r <= (bs_w == 8'd0) ? msfr_pkg::PH_CRC_HI : msfr_pkg::PH_PAYLOAD;
              end
              msfr_pkg::PH_PAYLOAD: begin
                pos_r <= pos_inc_w;
                crc_run_r <= crc_next_w;
                if (8'(pos_inc_w) >= flen_r) phase_r <= msfr_pkg::PH_CRC_HI;
              end
              msfr_pkg::PH_CRC_HI: begin
                crc_rcv_r <= {bs_w, 8'd0};
                phase_r <= msfr_pkg::PH_CRC_LO;
              end
              default: ;
            endcase
          end
          if (center_seen_r) missed_r <= 8'd0;
          else missed_r <= missed_w[7:0];
          bit_center_r <= bit_center_r + $signed({25'd0, bit_period_r})
                        + 41'(phase_nudge_r);
          phase_nudge_r <= 9'sd0;
          center_seen_r <= 1'b0;
          first_taken_r <= 1'b0;

          em_kind_r <= ev_kind_w;
          em_len_r <= flen_r;
          em_crc_r <= (ev_kind_w == msfr_pkg::KIND_GOOD ||
                       ev_kind_w == msfr_pkg::KIND_CRC_FAIL) ? rcv_full_w : 16'd0;
          em_idx_r <= '0;
          if (!emit_w) state_r <= ST_IDLE;
          else if (ev_kind_w != msfr_pkg::KIND_GOOD) state_r <= ST_STAT;
          else if (flen_r == 8'd0) state_r <= ST_FEND;
          else state_r <= ST_FRD;

          if (rs_w) begin
            if (ev_kind_w == msfr_pkg::KIND_LOCK_LOST) contrast_r <= 16'd0;
            phase_r <= msfr_pkg::PH_SEARCH; search_started_r <= 1'b0;
            search_prev_rising_r <= 1'b0; search_edge_count_r <= 8'd0;
            search_prev_at_r <= 32'd0; search_period_r <= {8'd0, nom_w};
            bit_center_r <= 41'sd0; bit_period_r <= nom_w; phase_nudge_r <= 9'sd0;
            center_seen_r <= 1'b0; missed_r <= 8'd0; first_taken_r <= 1'b0;
            first_sample_r <= 16'd0; start_shift_r <= 8'd0; start_bits_r <= 8'd0;
            byte_shift_r <= 8'd0; byte_cnt_r <= 3'd0; crc_run_r <= msfr_pkg::CRC_INIT;
            crc_rcv_r <= 16'd0; pos_r <= '0; flen_r <= 8'd0;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            out_valid_r <= 1'b1; out_kind_r <= em_kind_r; out_data_r <= 8'd0;
            out_crc_r <= em_crc_r; out_last_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        ST_FRD: state_r <= ST_FOUT;
        ST_FOUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1; out_kind_r <= msfr_pkg::KIND_BYTE; out_data_r <= mem_q_r;
            out_crc_r <= 16'd0; out_last_r <= 1'b0;
            em_idx_r <= em_idx_r + PW'(1);
            state_r <= (8'(em_idx_r) + 8'd1 < em_len_r) ? ST_FRD : ST_FEND;
          end
        end
        ST_FEND: begin
          if (out_free) begin
            out_valid_r <= 1'b1; out_kind_r <= msfr_pkg::KIND_GOOD; out_data_r <= em_len_r;
            out_crc_r <= em_crc_r; out_last_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_replay_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOUT) |-> (phase_r == msfr_pkg::PH_SEARCH))
    else $error("payload replay while a frame is still being parsed");
  a_count_per_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIT) |=> (sample_counter_r == $past(sample_counter_r) + 32'd1))
    else $error("sample counter did not advance on a decoded bit");
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FEND && out_free) |=>
      (out_valid_r && out_last_r && out_kind_r == msfr_pkg::KIND_GOOD))
    else $error("frame end result missing");
`endif

endmodule

`default_nettype wire

// ----- test/tb_manchester_sample_frame_receiver_top.sv -----
`timescale 1ns / 100ps

import msfr_pkg::*;

typedef struct {
  kind_t      kind;
  bit [7:0]   data;
  bit [15:0]  crc;
  bit         last;
} frame_result_t;

class frame_result_board;
  int unsigned half_cfg = 8, pre_cfg = 12, decay_cfg = 5, start_cfg = 213;
  int unsigned limit_cfg = 64, lost_cfg = 8, swing_cfg = 32, delta_cfg = 8;

  bit [31:0]   n_samples;
  bit          env_ready;
  longint      env_lo, env_hi;
  light_t      level;
  int unsigned contrast;
  phase_t      phase;
  bit          srch_started, srch_rising;
  int unsigned srch_edges;
  bit [31:0]   srch_prev_at;
  longint      srch_period, center, period, nudge;
  bit          center_seen;
  int unsigned missed;
  bit          first_taken;
  bit [15:0]   first_sample;
  bit [7:0]    start_shift, byte_sr;
  int unsigned start_seen, byte_cnt, pos, flen;
  bit [15:0]   crc_run, crc_rx;
  bit [7:0]    store [32];

  frame_result_t expected_results[$];
  frame_result_t step_out[$];
  int fails;
  int got;

  function new();
    n_samples = 0;
    env_ready = 0;
    env_lo = 0;
    env_hi = 0;
    level = LIGHT_UNKNOWN;
    contrast = 0;
    fails = 0;
    got = 0;
    restart_search();
  endfunction

  function void set_reg(logic [3:0] idx, logic [15:0] v);
    case (idx)
      REG_HALF_BIT:    half_cfg = v[5:0];
      REG_PREAMBLE:    pre_cfg = v[7:0];
      REG_DECAY_SHIFT: decay_cfg = v[3:0];
      REG_START_BYTE:  start_cfg = v[7:0];
      REG_START_LIMIT: limit_cfg = v[7:0];
      REG_LOST_LIMIT:  lost_cfg = v[7:0];
      REG_MIN_SWING:   swing_cfg = v;
      REG_MIN_DELTA:   delta_cfg = v;
      default: ;
    endcase
  endfunction

  function longint floor_shift(longint v, int unsigned s);
    longint m;
    if (v >= 0) return v >>> s;
    m = -v;
    return -((m + ((longint'(1) << s) - 1)) >>> s);
  endfunction

  function longint wrap41(longint c);
    longint u;
    u = c & ((longint'(1) << 41) - 1);
    if (u[40]) return u - (longint'(1) << 41);
    return u;
  endfunction

  function bit [31:0] to_index(longint v);
    longint r;
    if (v <= 0) return 0;
    r = (v + 128) / 256;
    if (r > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return r[31:0];
  endfunction

  function longint full_len();
    return 2 * ((half_cfg < 2) ? 2 : half_cfg);
  endfunction

  function longint bound_period(longint p);
    longint lo, hi;
    lo = (full_len() - 3) * 256;
    hi = (full_len() + 3) * 256;
    return (p < lo) ? lo : ((p > hi) ? hi : p);
  endfunction

  function bit [15:0] crc_step(bit [15:0] c, bit [7:0] b);
    c ^= {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function longint tol(longint p);
    longint t;
    t = (p / 256) / 4;
    return (t < 3) ? 3 : t;
  endfunction

  function void push_result(kind_t k, bit [7:0] d, bit [15:0] c);
    frame_result_t r;
    if (step_out.size() >= PAYLOAD_BYTES_DEF + 1) return;
    r.kind = k;
    r.data = d;
    r.crc = c;
    r.last = 0;
    step_out.push_back(r);
  endfunction

  function void restart_parser();
    start_shift = 0;
    start_seen = 0;
    byte_sr = 0;
    byte_cnt = 0;
    crc_run = CRC_INIT;
    crc_rx = 0;
    pos = 0;
    flen = 0;
  endfunction

  function void restart_search();
    phase = PH_SEARCH;
    srch_started = 0;
    srch_rising = 0;
    srch_edges = 0;
    srch_prev_at = 0;
    srch_period = full_len() * 256;
    center = 0;
    period = full_len() * 256;
    nudge = 0;
    center_seen = 0;
    missed = 0;
    first_taken = 0;
    first_sample = 0;
    restart_parser();
  endfunction

  function int unsigned swing();
    longint t;
    if (!env_ready || env_hi <= env_lo) return 0;
    t = (env_hi - env_lo) >>> 8;
    return t[15:0];
  endfunction

  function bit find_edge(bit [15:0] s, output bit rising);
    longint sq, mid, hy;
    int unsigned sw, h;
    rising = 0;
    sq = longint'(s) * 256;
    if (!env_ready) begin
      env_ready = 1;
      env_lo = sq;
      env_hi = sq;
      level = LIGHT_UNKNOWN;
      return 0;
    end
    env_lo += floor_shift(sq - env_lo, (sq < env_lo) ? 2 : decay_cfg);
    env_hi += floor_shift(sq - env_hi, (sq > env_hi) ? 2 : decay_cfg);
    sw = swing();
    if (sw < swing_cfg) begin
      level = LIGHT_UNKNOWN;
      return 0;
    end
    mid = (env_lo + env_hi) / 2;
    h = sw / 8;
    if (h < HYSTERESIS_FLOOR_DEF) h = HYSTERESIS_FLOOR_DEF;
    hy = longint'(h) * 256;
    if (level == LIGHT_UNKNOWN) begin
      level = (sq >= mid) ? LIGHT_HIGH : LIGHT_LOW;
      return 0;
    end
    if (level == LIGHT_LOW && sq > mid + hy) begin
      level = LIGHT_HIGH;
      rising = 1;
      return 1;
    end
    if (level == LIGHT_HIGH && sq < mid - hy) begin
      level = LIGHT_LOW;
      return 1;
    end
    return 0;
  endfunction

  function void preamble_edge(bit rising);
    bit [31:0] gap;
    longint exp_gap, err, tl;
    bit ok;
    if (!srch_started) begin
      srch_started = 1;
      srch_rising = rising;
      srch_edges = 1;
      srch_prev_at = n_samples;
      srch_period = full_len() * 256;
      return;
    end
    gap = n_samples - srch_prev_at;
    exp_gap = srch_period / 256;
    tl = tol(srch_period);
    err = longint'(gap) - exp_gap;
    ok = (rising != srch_rising) && err >= -tl && err <= tl;
    srch_rising = rising;
    srch_prev_at = n_samples;
    if (!ok) begin
      srch_edges = 1;
      srch_period = full_len() * 256;
      return;
    end
    srch_period += floor_shift(longint'(gap) * 256 - srch_period, 2);
    if (srch_period < 0) srch_period = 0;
    if (srch_period > 64'hFF_FFFF) srch_period = 64'hFF_FFFF;
    if (srch_edges < 255) srch_edges++;
    if (srch_edges >= pre_cfg) begin
      phase = PH_START;
      restart_parser();
      center = wrap41(longint'(n_samples) * 256 + srch_period);
      period = bound_period(srch_period);
      nudge = 0;
      center_seen = 0;
      missed = 0;
      first_taken = 0;
    end
  endfunction

  function void pll_edge();
    bit [31:0] diff;
    longint err, tl, n;
    diff = n_samples - to_index(center);
    err = longint'(signed'(diff));
    tl = tol(period);
    if (err < -tl || err > tl) return;
    n = err * 64;
    nudge = (n < -128) ? -128 : ((n > 128) ? 128 : n);
    period = bound_period(period + err * 8);
    center_seen = 1;
  endfunction

  function void take_byte(bit [7:0] b);
    case (phase)
      PH_LENGTH: begin
        flen = b;
        pos = 0;
        crc_run = crc_step(CRC_INIT, b);
        phase = (b == 0) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (pos >= PAYLOAD_BYTES_DEF) begin
          push_result(KIND_LEN_ERR, 0, 0);
          restart_search();
        end else begin
          store[pos] = b;
          pos++;
          crc_run = crc_step(crc_run, b);
          if (pos >= flen) phase = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_rx = {b, 8'h00};
        phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_rx = crc_rx | b;
        if (crc_rx == crc_run) begin
          for (int i = 0; i < flen && i < PAYLOAD_BYTES_DEF; i++)
            push_result(KIND_BYTE, store[i], 0);
          push_result(KIND_GOOD, flen[7:0], crc_rx);
        end else begin
          push_result(KIND_CRC_FAIL, 0, crc_rx);
        end
        restart_search();
      end
      default: ;
    endcase
  endfunction

  function void take_bit(bit b);
    int unsigned nxt;
    if (phase == PH_START) begin
      start_shift = {start_shift[6:0], b};
      nxt = start_seen + 1;
      if (start_shift == start_cfg) begin
        start_seen = nxt & 8'hFF;
        phase = PH_LENGTH;
        byte_sr = 0;
        byte_cnt = 0;
        crc_run = CRC_INIT;
        crc_rx = 0;
        pos = 0;
        flen = 0;
      end else if (nxt > limit_cfg) begin
        push_result(KIND_START_TO, 0, 0);
        restart_search();
      end else begin
        start_seen = nxt;
      end
      return;
    end
    byte_sr = {byte_sr[6:0], b};
    byte_cnt++;
    if (byte_cnt < 8) return;
    byte_cnt = 0;
    take_byte(byte_sr);
    byte_sr = 0;
  endfunction

  function void finish_bit(bit b, int unsigned strength);
    if (contrast == 0)
      contrast = strength;
    else
      contrast = longint'(contrast) +
                 floor_shift(longint'(strength) - longint'(contrast), CONTRAST_SHIFT_DEF);
    take_bit(b);
    if (phase == PH_SEARCH) return;
    if (center_seen) begin
      missed = 0;
    end else if (missed + 1 > lost_cfg) begin
      contrast = 0;
      restart_search();
      push_result(KIND_LOCK_LOST, 0, 0);
      return;
    end else begin
      missed++;
    end
    center = wrap41(center + period + nudge);
    nudge = 0;
    center_seen = 0;
    first_taken = 0;
  endfunction

  function void decode(bit [15:0] s);
    longint q;
    bit [31:0] fa, sa;
    int unsigned strength, thr, adapt;
    int d;
    if (phase == PH_SEARCH) return;
    q = period / 4;
    fa = to_index(center - q);
    sa = to_index(center + q);
    if (!first_taken && n_samples >= fa) begin
      first_sample = s;
      first_taken = 1;
    end
    if (first_taken && n_samples >= sa) begin
      d = int'(s) - int'(first_sample);
      strength = (d < 0) ? -d : d;
      thr = delta_cfg;
      adapt = (contrast > 0) ? contrast / 3 : swing() / 6;
      if (adapt > thr) thr = adapt;
      finish_bit(d > 0, (strength < thr) ? thr : strength);
    end
  endfunction

  function void note_sample(bit [15:0] s);
    bit rising;
    step_out.delete();
    if (find_edge(s, rising)) begin
      if (phase == PH_SEARCH) preamble_edge(rising);
      else pll_edge();
    end
    decode(s);
    n_samples++;
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endfunction

  function void check_result(logic [2:0] kind, logic [7:0] data, logic [15:0] crc,
                             logic last);
    frame_result_t e;
    if (expected_results.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result kind=%0d data=%0h crc=%0h last=%0b",
                 kind, data, crc, last);
      return;
    end
    e = expected_results.pop_front();
    got++;
    if (e.kind !== kind || e.data !== data || e.crc !== crc || e.last !== last) begin
      fails++;
      if (fails <= 10)
        $display("result mismatch: exp kind=%0d data=%0h crc=%0h last=%0b, got %0d %0h %0h %0b",
                 e.kind, e.data, e.crc, e.last, kind, data, crc, last);
    end
  endfunction
endclass

module tb_manchester_sample_frame_receiver_top;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic [15:0] in_sample = 0;
  logic        out_stall = 0;
  logic        cfg_valid = 0;
  logic [3:0]  cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic        in_stall, out_valid, out_last, cfg_ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_data;
  logic [15:0] out_frame_crc;

  frame_result_board board = new;
  logic [15:0] wave[$];
  int unsigned cur_half = 8, cur_pre = 12, cur_limit = 64, cur_lost = 8;
  bit [7:0]    cur_start = 8'hD5;
  int unsigned lvl_lo = 1000, lvl_hi = 4000;
  bit          quiet = 0;
  int          hold_req = 0;
  int          cycles = 0;
  int          rand_items = 0;

  manchester_sample_frame_receiver_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_data(out_data), .out_frame_crc(out_frame_crc), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_kind, out_data, out_frame_crc, out_last);

  // receiver side: a requested hold-off wins over random stalls
  initial forever begin
    @(posedge clk);
    if (hold_req > 0) begin
      out_stall <= 1;
      hold_req--;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 25);
    end
  end

  task send(logic [15:0] s);
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    board.note_sample(s);
  endtask

  task settle();
    in_valid <= 0;
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_reg(logic [3:0] idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task configure(int unsigned h, int unsigned pre, int unsigned dec, bit [7:0] st,
                 int unsigned lim, int unsigned lost, int unsigned sw, int unsigned dl);
    settle();
    write_reg(REG_HALF_BIT, h);
    write_reg(REG_PREAMBLE, pre);
    write_reg(REG_DECAY_SHIFT, dec);
    write_reg(REG_START_BYTE, st);
    write_reg(REG_START_LIMIT, lim);
    write_reg(REG_LOST_LIMIT, lost);
    write_reg(REG_MIN_SWING, sw);
    write_reg(REG_MIN_DELTA, dl);
    cur_half = (h < 2) ? 2 : h;
    cur_pre = (pre < 1) ? 1 : pre;
    cur_start = st;
    cur_limit = lim;
    cur_lost = lost;
  endtask

  task add_level(bit high, int n);
    repeat (n) wave.push_back((high ? lvl_hi : lvl_lo) + $urandom_range(0, 40));
  endtask

  task add_bit(bit b);
    add_level(!b, cur_half);
    add_level(b, cur_half);
  endtask

  task add_byte(bit [7:0] v);
    for (int i = 7; i >= 0; i--) add_bit(v[i]);
  endtask

  task add_preamble();
    lvl_lo = $urandom_range(500, 20000);
    lvl_hi = lvl_lo + $urandom_range(2000, 30000);
    add_level(0, 3 * cur_half);
    for (int i = 0; i < cur_pre + 3; i++) add_bit(i % 2 == 0);
  endtask

  // nbytes payload bytes sent; declared length is len_field instead when len_field >= 0
  task add_frame(int nbytes, bit bad_crc, int len_field);
    bit [7:0]  len, b;
    bit [15:0] crc;
    len = (len_field >= 0) ? len_field : nbytes;
    add_preamble();
    add_byte(cur_start);
    add_byte(len);
    crc = board.crc_step(CRC_INIT, len);
    for (int i = 0; i < nbytes; i++) begin
      b = $urandom_range(0, 255);
      add_byte(b);
      crc = board.crc_step(crc, b);
    end
    if (bad_crc) crc ^= 16'h1 << $urandom_range(0, 15);
    add_byte(crc[15:8]);
    add_byte(crc[7:0]);
    add_level(0, 4 * cur_half);
  endtask

  task add_timeout();
    add_preamble();
    for (int i = 0; i < cur_limit + 4; i++) add_bit(0);
  endtask

  task add_lock_loss();
    add_preamble();
    add_byte(cur_start);
    add_level(0, (cur_lost + 3) * 2 * cur_half);
  endtask

  task add_noise(int n);
    repeat (n) wave.push_back($urandom_range(0, 65535));
  endtask

  task play(int hold_at);
    for (int i = 0; i < wave.size(); i++) begin
      if (i == hold_at) hold_req = $urandom_range(300, 600);
      send(wave[i]);
    end
    wave.delete();
  endtask

  initial begin
    logic [15:0] edge_vals[$];
    int pick;
    edge_vals = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
                  16'h7FFF, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h0000, 16'hFFFF};
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    configure(2, 3, 5, 8'hD5, 64, 8, 32, 8);
    foreach (edge_vals[i]) send(edge_vals[i]);
    add_frame(0, 0, -1);
    play(-1);
    add_frame(3, 0, -1);
    play(-1);
    add_frame(2, 1, -1);
    play(-1);
    // longest frame: hold the receiver so the payload drain backs up the input
    add_frame(32, 0, -1);
    add_noise(40);
    play(wave.size() - 42);
    add_frame(33, 0, 40);
    play(-1);
    add_timeout();
    play(-1);
    add_lock_loss();
    play(-1);
    settle();

    // half bit below two, zero preamble count, tightest limits
    configure(0, 0, 0, 8'h00, 1, 1, 0, 0);
    add_frame(2, 0, -1);
    add_lock_loss();
    add_noise(20);
    play(-1);
    configure(1, 2, 1, 8'h3C, 40, 4, 16, 200);
    add_frame(4, 0, -1);
    play(-1);

    configure(63, 255, 15, 8'hFF, 255, 255, 65535, 65535);
    add_noise(30);
    play(-1);

    for (int f = 0; f < 300 && (rand_items < 170 || board.got < 60); f++) begin
      if (f % 6 == 0)
        configure($urandom_range(2, 3), $urandom_range(1, 8), $urandom_range(2, 8),
                  $urandom_range(0, 255), $urandom_range(24, 64), $urandom_range(1, 12),
                  $urandom_range(16, 500), $urandom_range(0, 200));
      quiet = (f >= 3 && f < 7);
      pick = $urandom_range(99);
      if (pick < 60) add_frame($urandom_range(0, 4), 0, -1);
      else if (pick < 72) add_frame($urandom_range(0, 4), 1, -1);
      else if (pick < 80) add_timeout();
      else if (pick < 88) add_lock_loss();
      else add_noise($urandom_range(5, 20));
      rand_items += wave.size();
      play(-1);
      if (f == 9) settle();
    end
    quiet = 0;

    settle();
    if (board.fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
